FILE: rtl/kwm_pkg.sv
// Package for the timestamp k-way merge block.
// Holds the shared types, codes and fixed widths; no dependencies.
// Used by the comparator unit and the top level.
package kwm_pkg;

  // Widths fixed by the event record and the source field.
  localparam int STAMP_W   = 64;
  localparam int CNT_W     = 5;
  localparam int SRC_LIMIT = 16;

  // Operation codes of an input request.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_END  = 1'b1;

  // One head slot as held in the head memory.
  typedef struct packed {
    logic signed [63:0] stamp;
    logic signed [63:0] kind;
    logic signed [63:0] value;
    logic        [15:0] cpu;
    logic        [7:0]  app;
    logic        [15:0] thread;
  } head_t;

  // Control from the sequencer to the shared comparator.
  typedef struct packed {
    logic clear;
    logic cand_vld;
  } kwm_min_ctl_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } kwm_state_t;

endpackage

FILE: rtl/kwm_in_if.sv
// Input request channel of the merge block: valid, ready and one event record.
// No dependencies.
interface kwm_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic        [3:0]  stream;
  logic        [15:0] cpu_id;
  logic        [7:0]  app_id;
  logic        [15:0] thread_no;
  logic signed [63:0] stamp;
  logic signed [63:0] event_kind;
  logic signed [63:0] event_data;

  modport source (output valid, op, stream, cpu_id, app_id, thread_no, stamp,
                  event_kind, event_data, input ready);
  modport sink (input valid, op, stream, cpu_id, app_id, thread_no, stamp,
                event_kind, event_data, output ready);
endinterface

FILE: rtl/kwm_out_if.sv
// Result channel of the merge block: valid, ready and one emitted event.
// No dependencies.
interface kwm_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] out_cpu;
  logic        [7:0]  out_app;
  logic        [4:0]  out_rank;
  logic        [15:0] out_thread;
  logic signed [63:0] out_stamp;
  logic signed [63:0] out_kind;
  logic signed [63:0] out_value;

  modport source (output valid, out_cpu, out_app, out_rank, out_thread, out_stamp,
                  out_kind, out_value, input ready);
  modport sink (input valid, out_cpu, out_app, out_rank, out_thread, out_stamp,
                out_kind, out_value, output ready);
endinterface

FILE: rtl/kwm_cfg_if.sv
// Configuration write channel of the merge block: valid, ready and the
// num_sources write data. No dependencies.
interface kwm_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: rtl/timestamp_kway_merge_top.sv
// Top level of the timestamp k-way merge block.
// Depends on kwm_pkg, kwm_in_if, kwm_out_if, kwm_cfg_if, kwm_ram and kwm_min_unit.
//
// Each request either pushes an event into the empty head slot of its source
// or marks the source as ended. When every open source in use holds a head,
// the head with the smallest signed stamp leaves, lowest source first on ties,
// with out_rank set to the source number plus one. Each request is followed
// by a readiness check; if a head can leave, the single stamp comparator then
// scans the sources in use, reading one head slot per cycle from the head
// memory, followed by a memory read of the winner and the emit step, which
// waits while an unread result still holds the output register. A finished
// result waits in the output register while the next request is taken in.
// The number of sources in use is the num_sources register clamped to the
// range 2 to the smaller of SOURCES and 16.
module timestamp_kway_merge_top import kwm_pkg::*; #(
  parameter int SOURCES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  kwm_cfg_if.sink   cfg_ch,
  kwm_in_if.sink    in_ch,
  kwm_out_if.source out_ch
);

  localparam int SLOTS = (SOURCES < SRC_LIMIT) ? SOURCES : SRC_LIMIT;
  localparam int SW    = $clog2(SLOTS);

  kwm_state_t state_r, state_nxt;

  logic [CNT_W-1:0] num_src_r;
  logic [CNT_W-1:0] n_eff;
  logic [SLOTS-1:0] head_full_r, head_full_nxt;
  logic [SLOTS-1:0] src_open_r, src_open_nxt;
  logic [SLOTS-1:0] in_use;
  logic             wait_any, any_full;

  logic [CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [SW-1:0]    rd_idx_r, rd_idx_nxt;
  logic             scan_issue;

  logic             in_acc, src_ok, push_ok, end_ok;
  logic [SW-1:0]    src_idx;
  head_t            head_wr, head_rd;
  logic [SW-1:0]    ram_raddr;

  kwm_min_ctl_t     min_ctl;
  logic             best_vld;
  logic [SW-1:0]    best_idx;
  logic             emit_go;

  logic             out_valid_r;
  head_t            out_head_r;
  logic [CNT_W-1:0] out_rank_r;

  // Cfg register; the user ensures writes are only made while the block is idle.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_src_r <= CNT_W'(SRC_LIMIT);
    end else if (cfg_ch.valid) begin
      num_src_r <= cfg_ch.data;
    end
  end

  // Number of sources in use, clamped to what the slots allow.
  always_comb begin
    if (num_src_r < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (num_src_r > CNT_W'(SLOTS)) begin
      n_eff = CNT_W'(SLOTS);
    end else begin
      n_eff = num_src_r;
    end
  end

  // Per-slot flags for sources in use, and the readiness test over them.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      in_use[i] = CNT_W'(i) < n_eff;
    end
    wait_any = |(in_use & src_open_r & ~head_full_r);
    any_full = |(in_use & head_full_r);
  end

  // Decode of an accepted request.
  always_comb begin
    in_acc  = in_ch.valid && in_ch.ready;
    src_ok  = {1'b0, in_ch.stream} < n_eff;
    src_idx = in_ch.stream[SW-1:0];
    push_ok = in_acc && src_ok && (in_ch.op == OP_PUSH) &&
              src_open_r[src_idx] && !head_full_r[src_idx];
    end_ok  = in_acc && src_ok && (in_ch.op == OP_END);
  end

  assign head_wr = '{stamp:  in_ch.stamp,
                     kind:   in_ch.event_kind,
                     value:  in_ch.event_data,
                     cpu:    in_ch.cpu_id,
                     app:    in_ch.app_id,
                     thread: in_ch.thread_no};

  // Head event memory: written on a push, read by the scan and for the winner.
  kwm_ram #(
    .WIDTH ($bits(head_t)),
    .DEPTH (SLOTS)
  ) u_head_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (src_idx),
    .wdata (head_wr),
    .raddr (ram_raddr),
    .rdata (head_rd)
  );

  // Shared comparator keeping the running minimum over the scan.
  kwm_min_unit #(
    .IDX_W (SW)
  ) u_min_unit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (min_ctl),
    .cand_stamp (head_rd.stamp),
    .cand_idx   (rd_idx_r),
    .best_vld   (best_vld),
    .best_idx   (best_idx)
  );

  assign scan_issue = scan_cnt_r < n_eff;
  assign emit_go    = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (wait_any || !any_full) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!scan_issue) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake, memory address and comparator control.
  always_comb begin
    in_ch.ready      = 1'b0;
    ram_raddr        = best_idx;
    min_ctl.clear    = 1'b0;
    min_ctl.cand_vld = 1'b0;
    scan_cnt_nxt     = scan_cnt_r;
    rd_vld_nxt       = 1'b0;
    rd_idx_nxt       = rd_idx_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
      end
      ST_CHECK: begin
        min_ctl.clear = 1'b1;
        scan_cnt_nxt  = '0;
      end
      ST_SCAN: begin
        ram_raddr        = scan_cnt_r[SW-1:0];
        min_ctl.cand_vld = rd_vld_r && head_full_r[rd_idx_r];
        rd_vld_nxt       = scan_issue;
        rd_idx_nxt       = scan_cnt_r[SW-1:0];
        if (scan_issue) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
        end
      end
      ST_READ: begin
        ram_raddr = best_idx;
      end
      ST_EMIT: begin
        ram_raddr = best_idx;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Full flag set by push, cleared as its event leaves; open flag cleared by end.
  always_comb begin
    head_full_nxt = head_full_r;
    src_open_nxt  = src_open_r;
    if (push_ok) begin
      head_full_nxt[src_idx] = 1'b1;
    end
    if (emit_go) begin
      head_full_nxt[best_idx] = 1'b0;
    end
    if (end_ok) begin
      src_open_nxt[src_idx] = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_full_r <= '0;
      src_open_r  <= '1;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_full_r <= head_full_nxt;
      src_open_r  <= src_open_nxt;
      rd_vld_r    <= rd_vld_nxt;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    scan_cnt_r <= scan_cnt_nxt;
    rd_idx_r   <= rd_idx_nxt;
  end

  // Output register holding the emitted event.
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_head_r <= head_rd;
      out_rank_r <= CNT_W'(best_idx) + CNT_W'(1);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_cpu    = out_head_r.cpu;
  assign out_ch.out_app    = out_head_r.app;
  assign out_ch.out_rank   = out_rank_r;
  assign out_ch.out_thread = out_head_r.thread;
  assign out_ch.out_stamp  = out_head_r.stamp;
  assign out_ch.out_kind   = out_head_r.kind;
  assign out_ch.out_value  = out_head_r.value;

  // An accepted request is always followed by the readiness check.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_CHECK)
    else $error("accepted request not followed by the readiness check");

  // The scan never runs past the number of sources in use.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> scan_cnt_r <= n_eff)
    else $error("scan counter beyond the sources in use");

  // A winner exists whenever the block reaches the emit step.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> best_vld && head_full_r[best_idx])
    else $error("emit step without a full winning slot");

  // The winning slot is empty once its event has left.
  assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |=> !head_full_r[$past(best_idx)] && out_valid_r)
    else $error("emitted slot still full or result not held");

endmodule

FILE: rtl/kwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the head event records of the merge block.
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/kwm_min_unit.sv
// Shared signed stamp comparator with its running-minimum register.
// Depends on kwm_pkg; fed one head slot per cycle by the top-level sequencer.
module kwm_min_unit import kwm_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  kwm_min_ctl_t              ctl,
  input  logic signed [STAMP_W-1:0] cand_stamp,
  input  logic        [IDX_W-1:0]   cand_idx,
  output logic                      best_vld,
  output logic        [IDX_W-1:0]   best_idx
);

  logic                      best_vld_r, best_vld_nxt;
  logic signed [STAMP_W-1:0] best_stamp_r, best_stamp_nxt;
  logic        [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic                      take;

  // Strictly smaller wins, so with an ascending scan the lowest source keeps ties.
  always_comb begin
    take           = ctl.cand_vld && (!best_vld_r || (cand_stamp < best_stamp_r));
    best_vld_nxt   = best_vld_r;
    best_stamp_nxt = best_stamp_r;
    best_idx_nxt   = best_idx_r;
    if (ctl.clear) begin
      best_vld_nxt = 1'b0;
    end else if (take) begin
      best_vld_nxt   = 1'b1;
      best_stamp_nxt = cand_stamp;
      best_idx_nxt   = cand_idx;
    end
  end

  // Only the valid flag needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_vld_r <= 1'b0;
    end else begin
      best_vld_r <= best_vld_nxt;
    end
    best_stamp_r <= best_stamp_nxt;
    best_idx_r   <= best_idx_nxt;
  end

  assign best_vld = best_vld_r;
  assign best_idx = best_idx_r;

endmodule
